@@ design/t9_keypad_substring_matcher_macros.svh @@
// Assertion macros for the keypad substring matcher
`ifndef T9_KEYPAD_SUBSTRING_MATCHER_MACROS_SVH
`define T9_KEYPAD_SUBSTRING_MATCHER_MACROS_SVH

// label: antecedent implies consequent in the same cycle
`define T9M_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// label: expression holds on every enabled clock edge
`define T9M_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

@@ design/t9m_pkg.sv @@
// Shared types and constants for the keypad substring matcher
package t9m_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int FIELD_MAX_DEF   = 100;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_W   = 64;
  localparam int LEN_W   = 5;
  localparam int CNT_W   = 7;
  localparam int TOTAL_W = 16;
  localparam int DIGIT_W = 4;

  localparam logic [DIGIT_W-1:0] NO_DIGIT  = 4'd15;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = 16'hFFFF;

  typedef enum logic [0:0] {
    CFG_PATTERN_DIGITS = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } t9m_cfg_idx_t;

  typedef struct packed {
    logic                eor;
    logic                is_number;
    logic [DIGIT_W-1:0]  digit;
  } t9m_entry_t;

endpackage

@@ design/t9_keypad_substring_matcher.sv @@
// Top level of the keypad substring matcher
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/ready    | in_req_type, in_char_code, in_number
//   out     | output    | out_valid/ready   | out_record_matched, out_total_matches
//   cfg     | input     | cfg_we            | cfg_index, cfg_data
// One item per cycle while in_ready is high. Classification is combinational, so a character
// is written into a queue slot when accepted and updates the search state as it leaves the queue.
// An end-of-record item leaves the queue only while the result register is empty or being read,
// and loads the result register as it leaves, so its result passes through both before it is taken.
// While a result waits in the output register, input keeps flowing until QUEUE_DEPTH
// items are queued; then in_ready drops. Reset is synchronous, active low, and
// clears pattern, search state and total.
module t9_keypad_substring_matcher #(
  parameter int PATTERN_MAX = t9m_pkg::PATTERN_MAX_DEF,
  parameter int FIELD_MAX   = t9m_pkg::FIELD_MAX_DEF,
  parameter int QUEUE_DEPTH = t9m_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [t9m_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_record_matched,
  output logic [t9m_pkg::TOTAL_W-1:0] out_total_matches
);

  `include "t9_keypad_substring_matcher_macros.svh"

  logic                q_full;
  logic                q_push;
  t9m_pkg::t9m_entry_t q_push_entry;
  logic                q_valid;
  t9m_pkg::t9m_entry_t q_head;
  logic                q_pop;

  t9m_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .in_number    (in_number),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_push_entry)
  );

  t9m_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .head_valid (q_valid),
    .head_entry (q_head),
    .pop        (q_pop)
  );

  t9m_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .FIELD_MAX   (FIELD_MAX)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_valid            (q_valid),
    .q_entry            (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_matched (out_record_matched),
    .out_total_matches  (out_total_matches)
  );

  `T9M_ASSERT_IMP(a_eor_waits_for_slot, q_valid && q_head.eor && out_valid && !out_ready, !q_pop, "end of record left the queue while a result was still held")
  `T9M_ASSERT_IMP(a_total_monotonic, $past(rst_n), out_total_matches >= $past(out_total_matches), "match total went down")
  `T9M_ASSERT_ALWAYS(a_match_counted, !out_valid || !out_record_matched || out_total_matches != '0, "matched record reported with a zero total")

endmodule

@@ design/t9m_front.sv @@
// Front end: accepts items and maps each character to its keypad digit
module t9m_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [7:0]           in_char_code,
  input  logic                 in_number,
  input  logic                 q_full,
  output logic                 q_push,
  output t9m_pkg::t9m_entry_t  q_entry
);

  function automatic logic [t9m_pkg::DIGIT_W-1:0] name_digit(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    if (c >= 8'd65 && c <= 8'd90) begin
      c = c + 8'd32;
    end
    if (c == 8'h2B) begin
      return 4'd0;
    end
    if (c < 8'h61 || c > 8'h7A) begin
      return t9m_pkg::NO_DIGIT;
    end
    if (c <= 8'h63) return 4'd2;
    if (c <= 8'h66) return 4'd3;
    if (c <= 8'h69) return 4'd4;
    if (c <= 8'h6C) return 4'd5;
    if (c <= 8'h6F) return 4'd6;
    if (c <= 8'h73) return 4'd7;
    if (c <= 8'h76) return 4'd8;
    return 4'd9;
  endfunction

  function automatic logic [t9m_pkg::DIGIT_W-1:0] number_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    if (c == 8'h2B) begin
      return 4'd0;
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      return d[t9m_pkg::DIGIT_W-1:0];
    end
    return t9m_pkg::NO_DIGIT;
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_entry.eor       = in_req_type;
    q_entry.is_number = in_number;
    q_entry.digit     = in_number ? number_digit(in_char_code) : name_digit(in_char_code);
  end

endmodule

@@ design/t9m_queue.sv @@
// Small item queue between the front end and the matcher
module t9m_queue #(
  parameter int DEPTH = t9m_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  t9m_pkg::t9m_entry_t  push_entry,
  output logic                 full,
  output logic                 head_valid,
  output t9m_pkg::t9m_entry_t  head_entry,
  input  logic                 pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  t9m_pkg::t9m_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ design/t9m_back.sv @@
// Back end: pattern registers, shift-and search and the result register
module t9m_back #(
  parameter int PATTERN_MAX = t9m_pkg::PATTERN_MAX_DEF,
  parameter int FIELD_MAX   = t9m_pkg::FIELD_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [t9m_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          q_valid,
  input  t9m_pkg::t9m_entry_t           q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_record_matched,
  output logic [t9m_pkg::TOTAL_W-1:0]   out_total_matches
);

  localparam int LW = t9m_pkg::LEN_W;
  localparam int CN = t9m_pkg::CNT_W;

  logic [t9m_pkg::CFG_W-1:0]   digits_r;
  logic [LW-1:0]               length_r;
  logic [PATTERN_MAX-1:0]      name_act_r, name_act_nxt;
  logic [PATTERN_MAX-1:0]      num_act_r, num_act_nxt;
  logic [CN-1:0]               name_cnt_r, name_cnt_nxt;
  logic [CN-1:0]               num_cnt_r, num_cnt_nxt;
  logic                        hit_r, hit_nxt;
  logic [t9m_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_matched_r, out_matched_nxt;
  logic [t9m_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic [LW-1:0]          len_eff;
  logic [PATTERN_MAX-1:0] digit_mask;
  logic [PATTERN_MAX-1:0] sel_act;
  logic [PATTERN_MAX-1:0] stepped;
  logic [CN-1:0]          sel_cnt;
  logic                   step_hit;
  logic                   char_take;
  logic                   matched;

  assign len_eff = (length_r > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : length_r;
  assign q_pop   = q_valid && (!q_entry.eor || !out_valid_r || out_ready);

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      digit_mask[j] = (LW'(j) < len_eff) && (q_entry.digit <= t9m_pkg::DIGIT_MAX)
                      && (digits_r[4*j +: 4] == q_entry.digit);
    end
    sel_act  = q_entry.is_number ? num_act_r : name_act_r;
    sel_cnt  = q_entry.is_number ? num_cnt_r : name_cnt_r;
    stepped  = ((sel_act << 1) | PATTERN_MAX'(1)) & digit_mask;
    step_hit = 1'b0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if ((LW'(j + 1) == len_eff) && stepped[j]) begin
        step_hit = 1'b1;
      end
    end
  end

  assign char_take = q_pop && !q_entry.eor && (sel_cnt < CN'(FIELD_MAX));
  assign matched   = hit_r || (len_eff == '0);

  always_comb begin
    name_act_nxt    = name_act_r;
    num_act_nxt     = num_act_r;
    name_cnt_nxt    = name_cnt_r;
    num_cnt_nxt     = num_cnt_r;
    hit_nxt         = hit_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_total_nxt   = out_total_r;
    if (char_take) begin
      if (q_entry.is_number) begin
        num_cnt_nxt = num_cnt_r + 1'b1;
      end else begin
        name_cnt_nxt = name_cnt_r + 1'b1;
      end
      if (len_eff != '0) begin
        if (q_entry.is_number) begin
          num_act_nxt = stepped;
        end else begin
          name_act_nxt = stepped;
        end
        hit_nxt = hit_r || step_hit;
      end
    end
    if (q_pop && q_entry.eor) begin
      if (matched && total_r != t9m_pkg::TOTAL_SAT) begin
        total_nxt = total_r + 1'b1;
      end
      out_valid_nxt   = 1'b1;
      out_matched_nxt = matched;
      out_total_nxt   = (matched && total_r != t9m_pkg::TOTAL_SAT) ? total_r + 1'b1 : total_r;
      name_act_nxt    = '0;
      num_act_nxt     = '0;
      name_cnt_nxt    = '0;
      num_cnt_nxt     = '0;
      hit_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r      <= '0;
      length_r      <= '0;
      name_act_r    <= '0;
      num_act_r     <= '0;
      name_cnt_r    <= '0;
      num_cnt_r     <= '0;
      hit_r         <= 1'b0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
      out_matched_r <= 1'b0;
      out_total_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (t9m_pkg::t9m_cfg_idx_t'(cfg_index))
          t9m_pkg::CFG_PATTERN_DIGITS: digits_r <= cfg_data;
          t9m_pkg::CFG_PATTERN_LENGTH: length_r <= cfg_data[LW-1:0];
          default: ;
        endcase
      end
      name_act_r    <= name_act_nxt;
      num_act_r     <= num_act_nxt;
      name_cnt_r    <= name_cnt_nxt;
      num_cnt_r     <= num_cnt_nxt;
      hit_r         <= hit_nxt;
      total_r       <= total_nxt;
      out_valid_r   <= out_valid_nxt;
      out_matched_r <= out_matched_nxt;
      out_total_r   <= out_total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_matched = out_matched_r;
  assign out_total_matches  = out_total_r;

endmodule

@@ tb/sv/tb_t9_keypad_substring_matcher.sv @@
// Self-checking testbench for the keypad substring matcher: directed script, then random records
module tb_t9_keypad_substring_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_CHAR     = 1'b0;
  localparam logic REQ_EOR      = 1'b1;
  localparam logic FIELD_NAME   = 1'b0;
  localparam logic FIELD_NUMBER = 1'b1;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_ROWS    = 32;

  typedef struct packed {
    logic                        hit;
    logic [t9m_pkg::TOTAL_W-1:0] total;
  } record_hit_t;

  typedef struct packed {
    logic                        is_cfg;
    t9m_pkg::t9m_cfg_idx_t       reg_sel;
    logic [t9m_pkg::CFG_W-1:0]   reg_val;
    logic                        req;
    logic [7:0]                  ch;
    logic                        fld;
    logic                        pinned;
    logic                        hit;
    logic [t9m_pkg::TOTAL_W-1:0] total;
  } script_row_t;

  logic                        clk;
  logic                        rst_n        = 1'b0;
  logic                        cfg_we       = 1'b0;
  logic [0:0]                  cfg_index    = '0;
  logic [t9m_pkg::CFG_W-1:0]   cfg_data     = '0;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic                        in_req_type  = 1'b0;
  logic [7:0]                  in_char_code = '0;
  logic                        in_number    = 1'b0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic                        out_record_matched;
  logic [t9m_pkg::TOTAL_W-1:0] out_total_matches;

  logic [t9m_pkg::CFG_W-1:0]           pat_digits = '0;
  logic [t9m_pkg::LEN_W-1:0]           pat_len    = '0;
  logic [t9m_pkg::PATTERN_MAX_DEF-1:0] name_live  = '0;
  logic [t9m_pkg::PATTERN_MAX_DEF-1:0] num_live   = '0;
  logic                                rec_hit    = 1'b0;
  logic [t9m_pkg::CNT_W-1:0]           name_cnt   = '0;
  logic [t9m_pkg::CNT_W-1:0]           num_cnt    = '0;
  logic [t9m_pkg::TOTAL_W-1:0]         hit_count  = '0;

  record_hit_t hits_due[$];
  bit          no_idle       = 1'b0;
  int          useful_items  = 0;
  int          results_seen  = 0;
  int          mismatches    = 0;
  int          settings_used = 0;
  int          quiet         = 0;

  script_row_t script [SCRIPT_ROWS] = '{
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b1, 1'b1, 16'd1},
    '{1'b1, t9m_pkg::CFG_PATTERN_DIGITS, 64'h32, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b1, t9m_pkg::CFG_PATTERN_LENGTH, 64'd2, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h41, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h44, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b1, 1'b1, 16'd2},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'hFF, FIELD_NUMBER, 1'b1, 1'b0, 16'd2},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h5A, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h63, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h33, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'hFF, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h00, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'hFF, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b1, 1'b0, 16'd2},
    '{1'b1, t9m_pkg::CFG_PATTERN_DIGITS, 64'hFFFF_FFFF_FFFF_FFFF, REQ_CHAR, 8'h00, FIELD_NAME,
      1'b0, 1'b0, 16'd0},
    '{1'b1, t9m_pkg::CFG_PATTERN_LENGTH, 64'd31, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h2B, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h2B, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b1, 1'b0, 16'd2},
    '{1'b1, t9m_pkg::CFG_PATTERN_DIGITS, 64'h10, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b1, t9m_pkg::CFG_PATTERN_LENGTH, 64'd2, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h2B, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h31, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b1, 1'b0, 16'd2},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h2B, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h31, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b1, 1'b1, 16'd3},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h30, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b1, t9m_pkg::CFG_PATTERN_DIGITS, 64'h50, REQ_CHAR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_CHAR, 8'h35, FIELD_NUMBER, 1'b0, 1'b0, 16'd0},
    '{1'b0, t9m_pkg::CFG_PATTERN_DIGITS, 64'd0, REQ_EOR, 8'h00, FIELD_NAME, 1'b0, 1'b0, 16'd0}
  };

  t9_keypad_substring_matcher dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_char_code       (in_char_code),
    .in_number          (in_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_matched (out_record_matched),
    .out_total_matches  (out_total_matches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_len();
    return (pat_len > t9m_pkg::PATTERN_MAX_DEF) ? t9m_pkg::PATTERN_MAX_DEF : int'(pat_len);
  endfunction

  function automatic logic [t9m_pkg::DIGIT_W-1:0] name_key(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
    if (l == CH_PLUS) return 4'd0;
    if (l < CH_LOWER_A || l > CH_LOWER_Z) return t9m_pkg::NO_DIGIT;
    if (l <= 8'h63) return 4'd2;
    if (l <= 8'h66) return 4'd3;
    if (l <= 8'h69) return 4'd4;
    if (l <= 8'h6C) return 4'd5;
    if (l <= 8'h6F) return 4'd6;
    if (l <= 8'h73) return 4'd7;
    if (l <= 8'h76) return 4'd8;
    return 4'd9;
  endfunction

  function automatic logic [t9m_pkg::DIGIT_W-1:0] number_key(input logic [7:0] c);
    logic [7:0] v;
    v = c - CH_ZERO;
    if (c == CH_PLUS) return 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) return v[t9m_pkg::DIGIT_W-1:0];
    return t9m_pkg::NO_DIGIT;
  endfunction

  function automatic logic [t9m_pkg::PATTERN_MAX_DEF-1:0] digit_mask(
      input logic [t9m_pkg::DIGIT_W-1:0] d);
    logic [t9m_pkg::PATTERN_MAX_DEF-1:0] m;
    m = '0;
    if (d <= t9m_pkg::DIGIT_MAX)
      for (int j = 0; j < eff_len(); j++)
        if (pat_digits[t9m_pkg::DIGIT_W*j +: t9m_pkg::DIGIT_W] == d) m[j] = 1'b1;
    return m;
  endfunction

  function automatic void shift_field(inout logic [t9m_pkg::PATTERN_MAX_DEF-1:0] live,
                                      inout logic [t9m_pkg::CNT_W-1:0] cnt,
                                      input logic [t9m_pkg::DIGIT_W-1:0] d);
    int unsigned n;
    n = eff_len();
    if (cnt >= t9m_pkg::FIELD_MAX_DEF) return;
    cnt = cnt + 1'b1;
    if (n == 0) return;
    live = {live[t9m_pkg::PATTERN_MAX_DEF-2:0], 1'b1} & digit_mask(d);
    if (live[n-1]) rec_hit = 1'b1;
  endfunction

  function automatic bit update_search(input logic req, input logic [7:0] ch,
                                       input logic fld, output record_hit_t res);
    res = '0;
    if (req == REQ_CHAR) begin
      if (fld == FIELD_NUMBER) shift_field(num_live, num_cnt, number_key(ch));
      else shift_field(name_live, name_cnt, name_key(ch));
      return 1'b0;
    end
    res.hit = rec_hit || eff_len() == 0;
    if (res.hit && hit_count != t9m_pkg::TOTAL_SAT) hit_count = hit_count + 1'b1;
    res.total = hit_count;
    name_live = '0;
    num_live  = '0;
    rec_hit   = 1'b0;
    name_cnt  = '0;
    num_cnt   = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = CH_LOWER_A + 8'($urandom_range(25));
    return $urandom_range(1) ? c - CASE_GAP : c;
  endfunction

  function automatic logic [7:0] noise_char(input logic fld);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return (fld == FIELD_NAME) ? rand_letter() : CH_ZERO + 8'($urandom_range(9));
    if (r < 52) return CH_PLUS;
    if (r < 62) return (fld == FIELD_NAME) ? CH_ZERO + 8'($urandom_range(9)) : rand_letter();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] key_char(input logic fld, input logic [t9m_pkg::DIGIT_W-1:0] d);
    logic [7:0]  first;
    int unsigned span;
    logic [7:0]  c;
    if (d > t9m_pkg::DIGIT_MAX || (fld == FIELD_NAME && d == 4'd1)) return noise_char(fld);
    if (d == 4'd0) return (fld == FIELD_NUMBER && $urandom_range(1)) ? CH_ZERO : CH_PLUS;
    if (fld == FIELD_NUMBER) return CH_ZERO + 8'(d);
    span = 3;
    unique case (d)
      4'd2: first = 8'h61;
      4'd3: first = 8'h64;
      4'd4: first = 8'h67;
      4'd5: first = 8'h6A;
      4'd6: first = 8'h6D;
      4'd7: begin
        first = 8'h70;
        span = 4;
      end
      4'd8: first = 8'h74;
      default: begin
        first = 8'h77;
        span = 4;
      end
    endcase
    c = first + 8'($urandom_range(span - 1));
    return $urandom_range(1) ? c - CASE_GAP : c;
  endfunction

  task automatic fill_field(input logic fld, ref logic [7:0] q[$]);
    int unsigned n;
    int unsigned plen;
    int unsigned at;
    q = {};
    n = ($urandom_range(99) < 5) ? $urandom_range(110, 95) : $urandom_range(18, 0);
    repeat (n) q.push_back(noise_char(fld));
    plen = eff_len();
    if (plen != 0 && $urandom_range(3) == 0) plen--;
    if (plen != 0 && plen <= n && $urandom_range(99) < 60) begin
      at = $urandom_range(n - plen);
      for (int j = 0; j < plen; j++)
        q[at + j] = key_char(fld, pat_digits[t9m_pkg::DIGIT_W*j +: t9m_pkg::DIGIT_W]);
    end
  endtask

  task automatic send_item(input logic req, input logic [7:0] ch, input logic fld,
                           input logic pinned = 1'b0, input logic pin_hit = 1'b0,
                           input logic [t9m_pkg::TOTAL_W-1:0] pin_total = '0);
    record_hit_t res;
    if (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_code <= ch;
    in_number    <= fld;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_EOR || ((fld == FIELD_NUMBER) ? num_cnt : name_cnt) < t9m_pkg::FIELD_MAX_DEF)
      useful_items++;
    if (update_search(req, ch, fld, res)) begin
      if (pinned) begin
        res.hit   = pin_hit;
        res.total = pin_total;
      end
      hits_due.push_back(res);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input t9m_pkg::t9m_cfg_idx_t sel,
                           input logic [t9m_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    if (sel == t9m_pkg::CFG_PATTERN_DIGITS) pat_digits = val;
    else pat_len = val[t9m_pkg::LEN_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) out_ready <= no_idle || ($urandom_range(99) >= 35);

  always @(posedge clk) begin
    record_hit_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (hits_due.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected result at %0t: record_matched %0b total_matches %0d",
                   $time, out_record_matched, out_total_matches);
        mismatches++;
      end else begin
        want = hits_due.pop_front();
        if (out_record_matched !== want.hit || out_total_matches !== want.total) begin
          if (mismatches < 10)
            $display("tb: mismatch at %0t: matched exp %0b got %0b, total exp %0d got %0d",
                     $time, want.hit, out_record_matched, want.total, out_total_matches);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    script_row_t               row;
    logic [t9m_pkg::CFG_W-1:0] dig;
    logic [t9m_pkg::LEN_W-1:0] len;
    int                        nrec;
    int                        base_items;
    int                        done;
    bit                        pick_num;
    logic [7:0]                name_q[$];
    logic [7:0]                num_q[$];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      row = script[i];
      if (row.is_cfg) begin
        drain_results();
        cfg_write(row.reg_sel, row.reg_val);
      end else begin
        send_item(row.req, row.ch, row.fld, row.pinned, row.hit, row.total);
      end
    end

    base_items = useful_items;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(9))
        0: dig = '0;
        1: dig = '1;
        2: dig = {$urandom, $urandom};
        default: begin
          for (int j = 0; j < t9m_pkg::PATTERN_MAX_DEF; j++) begin
            if ($urandom_range(99) < 6)
              dig[t9m_pkg::DIGIT_W*j +: t9m_pkg::DIGIT_W] = 4'($urandom_range(15, 10));
            else if ($urandom_range(99) < 9)
              dig[t9m_pkg::DIGIT_W*j +: t9m_pkg::DIGIT_W] = 4'd1;
            else
              dig[t9m_pkg::DIGIT_W*j +: t9m_pkg::DIGIT_W] = 4'($urandom_range(9));
          end
        end
      endcase
      case ($urandom_range(19))
        0, 1: len = '0;
        2, 3: len = 5'd16;
        4:    len = 5'($urandom_range(31, 17));
        default: len = 5'($urandom_range(6, 1));
      endcase
      if ($urandom_range(1)) begin
        cfg_write(t9m_pkg::CFG_PATTERN_DIGITS, dig);
        cfg_write(t9m_pkg::CFG_PATTERN_LENGTH, t9m_pkg::CFG_W'(len));
      end else begin
        cfg_write(t9m_pkg::CFG_PATTERN_LENGTH, t9m_pkg::CFG_W'(len));
        cfg_write(t9m_pkg::CFG_PATTERN_DIGITS, dig);
      end
      settings_used++;
      nrec = $urandom_range(6, 1);
      for (int r = 0; r < nrec; r++) begin
        done = useful_items - base_items;
        no_idle = (done >= 700 && done < 1000);
        fill_field(FIELD_NAME, name_q);
        fill_field(FIELD_NUMBER, num_q);
        if ($urandom_range(99) < 80) begin
          foreach (name_q[k]) send_item(REQ_CHAR, name_q[k], FIELD_NAME);
          foreach (num_q[k]) send_item(REQ_CHAR, num_q[k], FIELD_NUMBER);
        end else begin
          while (name_q.size() + num_q.size() != 0) begin
            pick_num = (name_q.size() == 0) || (num_q.size() != 0 && $urandom_range(1));
            if (pick_num) send_item(REQ_CHAR, num_q.pop_front(), FIELD_NUMBER);
            else send_item(REQ_CHAR, name_q.pop_front(), FIELD_NAME);
          end
        end
        if (r < nrec - 1 || $urandom_range(99) >= 15)
          send_item(REQ_EOR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      done = useful_items - base_items;
    end

    no_idle = 1'b0;
    send_item(REQ_EOR, 8'h00, FIELD_NAME);
    drain_results();

    $display("tb: %0d items taken, %0d record results checked, %0d pattern settings",
             useful_items, results_seen, settings_used);
    $display("tb: %0d mismatches", mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
